// ===== sv/cpr_pkg.sv =====
`default_nettype none
package cpr_pkg;

  localparam int WS_SLOTS   = 32;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int SLOT_W     = $clog2(WS_SLOTS);
  localparam int FILL_W     = $clog2(WS_SLOTS + 1);
  localparam int LIMIT_W    = 6;
  localparam int CMP_W      = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 5;
  localparam int EVICT_W    = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_PLACED   = 3'd2,
    ST_REPLACED = 3'd3,
    ST_RESIDENT = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY = 1'b0,
    REG_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_TOUCH,
    CMD_PLACE,
    CMD_LOAD,
    CMD_STEP,
    CMD_REPLACE
  } cell_cmd_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_cmd_e         cmd;
    logic [PAGE_W-1:0] page;
    logic              wr;
    logic              clr;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] hand;
  } cell_bus_t;

  // status of one cell back to the controller
  typedef struct packed {
    logic              match;
    logic              used;
    logic              dirty;
    logic              tok;
    logic              last;
    logic              fwd;
    logic [PAGE_W-1:0] page;
  } cell_st_t;

endpackage
`default_nettype wire

// ===== sv/cpr_if.sv =====
`default_nettype none
interface cpr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cpr_pkg::ADDR_W-1:0]    vaddr;
  logic                          is_write;

  modport source (output valid, output req_type, output vaddr, output is_write, input ready);
  modport sink   (input valid, input req_type, input vaddr, input is_write, output ready);
endinterface

interface cpr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cpr_pkg::STATUS_W-1:0]   status;
  logic [cpr_pkg::OUT_SLOT_W-1:0] slot;
  logic [cpr_pkg::EVICT_W-1:0]    evicted_page;
  logic                           writeback;

  modport source (output valid, output status, output slot, output evicted_page,
                  output writeback, input ready);
  modport sink   (input valid, input status, input slot, input evicted_page,
                  input writeback, output ready);
endinterface

interface cpr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpr_pkg::CFG_IDX_W-1:0]  index;
  logic [cpr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/clock_page_replacement.sv =====
`default_nettype none
// Clock page replacement engine: a row of slot cells, each holding a page number with its used
// and modified bits, matched in parallel against the requested page. Access words and faults
// that hit or are placed in a free slot are accepted, then looked up with the result registered.
// A fault that must evict walks the clock hand as a token passed from cell to cell, one slot a
// cycle; the number of slots it steps over before the victim is at most the resident count
// for plain clock and below four times the resident count for modified clock. One word is in
// work at a time; the result register lets the next request be accepted while a result waits
// on the output.
module clock_page_replacement (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpr_req_if.sink   req_i,
  cpr_rsp_if.source rsp_o,
  cpr_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_WRITE} state_e;

  state_e state_q, state_d;

  logic                           policy_q;
  logic [cpr_pkg::LIMIT_W-1:0]    limit_q;
  logic [cpr_pkg::PAGE_W-1:0]     page_q;
  logic                           req_q, wr_q;
  logic [cpr_pkg::FILL_W-1:0]     fill_q, fill_d;
  logic [cpr_pkg::SLOT_W-1:0]     hand_q, hand_d;
  logic                           phase_q, phase_d;
  logic [cpr_pkg::FILL_W-1:0]     cnt_q, cnt_d;

  logic                           out_valid_q, out_valid_d;
  logic [cpr_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [cpr_pkg::OUT_SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [cpr_pkg::EVICT_W-1:0]    out_evict_q, out_evict_d;
  logic                           out_wb_q, out_wb_d;

  cpr_pkg::cell_bus_t bus;
  cpr_pkg::cell_st_t  st [cpr_pkg::WS_SLOTS];
  logic               tok_in [cpr_pkg::WS_SLOTS];

  logic                       hit, tok_used, tok_dirty, wrap;
  logic [cpr_pkg::SLOT_W-1:0] hit_idx, tok_idx, hand_eff;
  logic [cpr_pkg::PAGE_W-1:0] tok_page;
  logic [cpr_pkg::CMP_W-1:0]  lim_eff;
  logic                       out_free, in_acc, found;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_comb begin
    if (limit_q == '0) begin
      lim_eff = cpr_pkg::CMP_W'(1);
    end else if (cpr_pkg::CMP_W'(limit_q) > cpr_pkg::CMP_W'(cpr_pkg::WS_SLOTS)) begin
      lim_eff = cpr_pkg::CMP_W'(cpr_pkg::WS_SLOTS);
    end else begin
      lim_eff = cpr_pkg::CMP_W'(limit_q);
    end
  end

  assign hand_eff = (cpr_pkg::FILL_W'(hand_q) >= fill_q) ? '0 : hand_q;

  // cell row; the hand token wraps from the last filled slot back to slot zero
  for (genvar gi = 0; gi < cpr_pkg::WS_SLOTS; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      assign tok_in[gi] = wrap;
    end else begin : g_link
      assign tok_in[gi] = st[gi-1].fwd;
    end
    cpr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (cpr_pkg::SLOT_W'(gi)),
      .bus_i  (bus),
      .tok_i  (tok_in[gi]),
      .st_o   (st[gi])
    );
  end

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    tok_used  = 1'b0;
    tok_dirty = 1'b0;
    tok_page  = '0;
    tok_idx   = '0;
    wrap      = 1'b0;
    for (int i = 0; i < cpr_pkg::WS_SLOTS; i++) begin
      hit  = hit | st[i].match;
      wrap = wrap | (st[i].tok & st[i].last);
      if (st[i].match) hit_idx = hit_idx | cpr_pkg::SLOT_W'(i);
      if (st[i].tok) begin
        tok_used  = tok_used | st[i].used;
        tok_dirty = tok_dirty | st[i].dirty;
        tok_page  = tok_page | st[i].page;
        tok_idx   = tok_idx | cpr_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (policy_q) begin
      found = !tok_used && (phase_q ? tok_dirty : !tok_dirty);
    end else begin
      found = !tok_used;
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    hand_d       = hand_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_evict_d  = out_evict_q;
    out_wb_d     = out_wb_q;

    bus.cmd  = cpr_pkg::CMD_IDLE;
    bus.page = page_q;
    bus.wr   = wr_q;
    bus.clr  = !policy_q || phase_q;
    bus.fill = fill_q;
    bus.hand = hand_eff;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (req_q && !hit && (cpr_pkg::CMP_W'(fill_q) >= lim_eff)) begin
          bus.cmd = cpr_pkg::CMD_LOAD;
          phase_d = 1'b0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_evict_d = '0;
          out_wb_d    = 1'b0;
          state_d     = S_IDLE;
          if (!req_q) begin
            bus.cmd      = cpr_pkg::CMD_TOUCH;
            out_status_d = hit ? cpr_pkg::ST_HIT : cpr_pkg::ST_MISS;
            out_slot_d   = hit ? cpr_pkg::OUT_SLOT_W'(hit_idx) : '0;
          end else if (hit) begin
            out_status_d = cpr_pkg::ST_RESIDENT;
            out_slot_d   = cpr_pkg::OUT_SLOT_W'(hit_idx);
          end else begin
            bus.cmd      = cpr_pkg::CMD_PLACE;
            out_status_d = cpr_pkg::ST_PLACED;
            out_slot_d   = cpr_pkg::OUT_SLOT_W'(fill_q);
            fill_d       = fill_q + cpr_pkg::FILL_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          state_d = S_WRITE;
        end else begin
          bus.cmd = cpr_pkg::CMD_STEP;
          // a full lap of the resident slots ends one modified-clock pass
          if (cnt_q == fill_q - cpr_pkg::FILL_W'(1)) begin
            cnt_d   = '0;
            phase_d = !phase_q;
          end else begin
            cnt_d = cnt_q + cpr_pkg::FILL_W'(1);
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          bus.cmd      = cpr_pkg::CMD_REPLACE;
          out_valid_d  = 1'b1;
          out_status_d = cpr_pkg::ST_REPLACED;
          out_slot_d   = cpr_pkg::OUT_SLOT_W'(tok_idx);
          out_evict_d  = cpr_pkg::EVICT_W'(tok_page);
          out_wb_d     = tok_dirty;
          if ((cpr_pkg::FILL_W'(tok_idx) + cpr_pkg::FILL_W'(1)) >= fill_q) begin
            hand_d = '0;
          end else begin
            hand_d = tok_idx + cpr_pkg::SLOT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= 1'b0;
      limit_q     <= cpr_pkg::LIMIT_W'(32);
      fill_q      <= '0;
      hand_q      <= '0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      hand_q      <= hand_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          cpr_pkg::REG_POLICY: policy_q <= cfg_i.data[0];
          cpr_pkg::REG_LIMIT:  limit_q  <= cfg_i.data[cpr_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_i.req_type;
      wr_q   <= req_i.is_write;
      page_q <= req_i.vaddr[cpr_pkg::ADDR_W-1:cpr_pkg::PAGE_SHIFT];
    end
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_evict_q  <= out_evict_d;
    out_wb_q     <= out_wb_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot         = out_slot_q;
  assign rsp_o.evicted_page = out_evict_q;
  assign rsp_o.writeback    = out_wb_q;

endmodule
`default_nettype wire

// ===== sv/cpr_cell.sv =====
`default_nettype none
module cpr_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [cpr_pkg::SLOT_W-1:0]    idx_i,
  input  wire cpr_pkg::cell_bus_t            bus_i,
  input  wire logic                          tok_i,
  output cpr_pkg::cell_st_t                  st_o
);

  logic [cpr_pkg::PAGE_W-1:0] page_q, page_d;
  logic used_q, used_d;
  logic dirty_q, dirty_d;
  logic tok_q, tok_d;
  logic filled, last, at_fill, match;

  assign filled  = cpr_pkg::FILL_W'(idx_i) < bus_i.fill;
  assign at_fill = cpr_pkg::FILL_W'(idx_i) == bus_i.fill;
  assign last    = (cpr_pkg::FILL_W'(idx_i) + cpr_pkg::FILL_W'(1)) == bus_i.fill;
  assign match   = filled && (page_q == bus_i.page);

  always_comb begin
    page_d  = page_q;
    used_d  = used_q;
    dirty_d = dirty_q;
    tok_d   = tok_q;
    unique case (bus_i.cmd)
      cpr_pkg::CMD_IDLE: begin
      end
      cpr_pkg::CMD_TOUCH: begin
        if (match) begin
          used_d = 1'b1;
          if (bus_i.wr) dirty_d = 1'b1;
        end
      end
      cpr_pkg::CMD_PLACE: begin
        if (at_fill) begin
          page_d  = bus_i.page;
          used_d  = 1'b1;
          dirty_d = 1'b0;
        end
      end
      cpr_pkg::CMD_LOAD: begin
        tok_d = (idx_i == bus_i.hand);
      end
      cpr_pkg::CMD_STEP: begin
        // pass the hand on; clear used where the hand sweeps in clearing passes
        tok_d = tok_i;
        if (tok_q && bus_i.clr) used_d = 1'b0;
      end
      cpr_pkg::CMD_REPLACE: begin
        if (tok_q) begin
          page_d  = bus_i.page;
          used_d  = 1'b1;
          dirty_d = 1'b0;
        end
        tok_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      dirty_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      used_q  <= used_d;
      dirty_q <= dirty_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign st_o.match = match;
  assign st_o.used  = used_q;
  assign st_o.dirty = dirty_q;
  assign st_o.tok   = tok_q;
  assign st_o.last  = last;
  assign st_o.fwd   = tok_q && !last;
  assign st_o.page  = page_q;

endmodule
`default_nettype wire
